// File: hdl/rgb_sharpen_3x3_filter_macros.svh
// assertion macros shared by the sharpen filter rtl
`ifndef RGB_SHARPEN_3X3_FILTER_MACROS_SVH
`define RGB_SHARPEN_3X3_FILTER_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/rsf_pkg.sv
// types and constants of the rgb sharpen filter
`timescale 1ns / 1ps
`default_nettype none
package rsf_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 12;
  localparam int HEIGHT_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int CHAN_W     = 8;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(768);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } rsf_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   red_out;
    logic [CHAN_W-1:0]   green_out;
    logic [CHAN_W-1:0]   blue_out;
    logic [COL_W-1:0]    out_column;
    logic [HEIGHT_W-1:0] out_row;
    logic                last_pixel;
  } rsf_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } rsf_pix_t;

  // one line store entry: the two rows above the incoming pixel
  typedef struct packed {
    rsf_pix_t upper;
    rsf_pix_t middle;
  } rsf_line_t;

  // position info riding along with a pixel
  typedef struct packed {
    logic                emit;
    logic                last;
    logic [COL_W-1:0]    column;
    logic [HEIGHT_W-1:0] row;
  } rsf_meta_t;

endpackage
`default_nettype wire

// File: hdl/rsf_line_store.sv
// two-row line store, one read and one write port, registered read
`timescale 1ns / 1ps
`default_nettype none
module rsf_line_store
  import rsf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [COL_W-1:0] rd_addr,
  output rsf_line_t             rd_data,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] wr_addr,
  input  wire rsf_line_t        wr_data
);

  rsf_line_t mem_r [MAX_WIDTH];
  rsf_line_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: hdl/rsf_lane.sv
// one color lane: sharpen kernel on a cross of five samples, clamped
`timescale 1ns / 1ps
`default_nettype none
module rsf_lane
  import rsf_pkg::*;
(
  input  wire logic [CHAN_W-1:0] center,
  input  wire logic [CHAN_W-1:0] up,
  input  wire logic [CHAN_W-1:0] down,
  input  wire logic [CHAN_W-1:0] left,
  input  wire logic [CHAN_W-1:0] right,
  output logic      [CHAN_W-1:0] result
);

  logic signed [CHAN_W+3:0] sum;

  always_comb begin
    // 5 * center as (center << 2) + center
    sum = signed'({2'b00, center, 2'b00}) + signed'({4'b0000, center})
        - signed'({4'b0000, up}) - signed'({4'b0000, down})
        - signed'({4'b0000, left}) - signed'({4'b0000, right});
    if (sum[CHAN_W+3]) begin
      result = '0;
    end else if (|sum[CHAN_W+2:CHAN_W]) begin
      result = '1;
    end else begin
      result = sum[CHAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/rgb_sharpen_3x3_filter.sv
// top level: rgb 3x3 sharpen filter over a raster pixel stream
// an accepted word passes stage 1, stage 2 and the output register before it shows on out_valid
// throughput: one word per cycle when not stalled; line store read and write ports each used once a cycle
// border pixels produce no output word, so out words are fewer than in words
// reset (rst_n low, synchronous): counters to zero, pipeline emptied,
// image_width 1024, image_height 768; line store and window keep stale data
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_sharpen_3x3_filter_macros.svh"
module rgb_sharpen_3x3_filter
  import rsf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire rsf_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output rsf_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;

  // raster position of the next input word
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;

  // whole pipeline moves together; only a stalled output word holds it
  logic adv;
  logic in_acc;

  // effective sizes and end-of-row / end-of-image detection
  logic [WIDTH_W-1:0]  width_eff;
  logic [HEIGHT_W-1:0] height_eff;
  logic                row_end;
  logic                img_end;
  rsf_meta_t           meta_nxt;

  // stage 1: pixel waiting for its line store read
  logic       s1_valid_r;
  rsf_pix_t   s1_pix_r;
  rsf_meta_t  s1_meta_r;
  logic [COL_W-1:0] s1_addr_r;

  // line store
  rsf_line_t  line_rd;
  rsf_line_t  line_wr;
  logic       mem_wr_en;

  // 3x3 window, only the taps the kernel uses plus the right column
  rsf_pix_t top_c_r, top_r_r;
  rsf_pix_t mid_l_r, mid_c_r, mid_r_r;
  rsf_pix_t bot_c_r, bot_r_r;

  // stage 2: window holds this pixel's neighborhood
  logic      s2_valid_r;
  rsf_meta_t s2_meta_r;

  // lane results and output register
  logic [CHAN_W-1:0] red_res, green_res, blue_res;
  rsf_out_t          out_data_r, out_data_nxt;
  logic              out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_acc   = in_valid && adv;
  assign in_stall = !adv;

  // ---------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // raster counters and per-word position info
  // ---------------------------------------------------------------
  always_comb begin
    // width saturated to 3..MAX_WIDTH, height to at least 3
    if (width_r < WIDTH_MIN) begin
      width_eff = WIDTH_MIN;
    end else if (width_r > WIDTH_MAX) begin
      width_eff = WIDTH_MAX;
    end else begin
      width_eff = width_r;
    end
    height_eff = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;

    row_end = {{(WIDTH_W-COL_W){1'b0}}, col_r} >= (width_eff - WIDTH_W'(1));
    img_end = row_r >= (height_eff - HEIGHT_W'(1));

    // interior once two full rows and two columns are behind the window
    meta_nxt.emit   = (col_r >= COL_W'(2)) && (row_r >= HEIGHT_W'(2));
    meta_nxt.last   = row_end && img_end;
    meta_nxt.column = col_r - COL_W'(1);
    meta_nxt.row    = row_r - HEIGHT_W'(1);

    if (row_end) begin
      col_nxt = '0;
      row_nxt = img_end ? '0 : row_r + HEIGHT_W'(1);
    end else begin
      col_nxt = col_r + COL_W'(1);
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: issue line store read at the current column
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r.red   <= in_data.red_in;
      s1_pix_r.green <= in_data.green_in;
      s1_pix_r.blue  <= in_data.blue_in;
      s1_meta_r      <= meta_nxt;
      s1_addr_r      <= col_r;
    end
  end

  // write back as the word leaves stage 1: middle row moves up, new pixel
  // becomes the middle row; the next read is always at another column
  assign mem_wr_en      = s1_valid_r && adv;
  assign line_wr.upper  = line_rd.middle;
  assign line_wr.middle = s1_pix_r;

  rsf_line_store u_line_store (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (mem_wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (line_wr)
  );

  // ---------------------------------------------------------------
  // stage 2: slide the window one column
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      top_c_r <= top_r_r;
      top_r_r <= line_rd.upper;
      mid_l_r <= mid_c_r;
      mid_c_r <= mid_r_r;
      mid_r_r <= line_rd.middle;
      bot_c_r <= bot_r_r;
      bot_r_r <= s1_pix_r;
    end
  end

  // only interior words go on; border words just feed the window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r && s1_meta_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // ---------------------------------------------------------------
  // three color lanes side by side
  // ---------------------------------------------------------------
  rsf_lane u_lane_red (
    .center (mid_c_r.red),
    .up     (top_c_r.red),
    .down   (bot_c_r.red),
    .left   (mid_l_r.red),
    .right  (mid_r_r.red),
    .result (red_res)
  );

  rsf_lane u_lane_green (
    .center (mid_c_r.green),
    .up     (top_c_r.green),
    .down   (bot_c_r.green),
    .left   (mid_l_r.green),
    .right  (mid_r_r.green),
    .result (green_res)
  );

  rsf_lane u_lane_blue (
    .center (mid_c_r.blue),
    .up     (top_c_r.blue),
    .down   (bot_c_r.blue),
    .left   (mid_l_r.blue),
    .right  (mid_r_r.blue),
    .result (blue_res)
  );

  // ---------------------------------------------------------------
  // merge lanes with position into the output word
  // ---------------------------------------------------------------
  always_comb begin
    out_data_nxt.red_out    = red_res;
    out_data_nxt.green_out  = green_res;
    out_data_nxt.blue_out   = blue_res;
    out_data_nxt.out_column = s2_meta_r.column;
    out_data_nxt.out_row    = s2_meta_r.row;
    out_data_nxt.last_pixel = s2_meta_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  `RSF_ASSERT_IMPL(a_no_rw_collision, mem_wr_en && in_acc, s1_addr_r != col_r, "rw collision")
  `RSF_ASSERT_NEXT(a_image_wrap, in_acc && row_end && img_end, col_r == '0 && row_r == '0, "no wrap")
  `RSF_ASSERT_IMPL(a_interior_only, out_valid, |out_data.out_column && |out_data.out_row, "border")
  `RSF_ASSERT_NEXT(a_s2_from_s1, adv && !(s1_valid_r && s1_meta_r.emit), !s2_valid_r, "s2 fill")

endmodule
`default_nettype wire

// File: tb/rgb_sharpen_3x3_filter_tb.sv
// testbench for the rgb 3x3 sharpen filter: predictor, scoreboard, directed and random images
`timescale 1ns / 1ps
module rgb_sharpen_3x3_filter_tb;
  import rsf_pkg::*;

  localparam int HOLD_OFF_CYCLES = 240;  // long receiver hold-off, fills the pipeline
  localparam int QUIET_LIMIT     = 5000; // cycles with no word moved before giving up
  localparam int SETTLE_CYCLES   = 8;    // pause after the last owed result, a margin for the block to drain
  localparam int RANDOM_WORDS    = 360;

  // clock and reset
  logic clk;
  logic rst_n = 1'b0;

  // block ports
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  rsf_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  rsf_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // traffic shaping
  bit steady     = 1'b0;  // no random idling on either side while set
  bit hold_start = 1'b0;  // one-cycle pulse starts the long receiver hold-off
  int hold_left  = 0;

  // predictor state, mirrors the block's line stores, window and counters
  rsf_pix_t           upper_line  [MAX_WIDTH];
  rsf_pix_t           middle_line [MAX_WIDTH];
  rsf_pix_t           window_px   [9];
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  int                  next_col;
  int                  next_row;

  // sharpened pixels still owed by the block, oldest first
  rsf_out_t expected_pixels[$];
  rsf_out_t want;

  // run statistics
  int failures        = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int images_closed   = 0;
  int quiet_cycles    = 0;

  rgb_sharpen_3x3_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_model();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    next_col   = 0;
    next_row   = 0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 9; i++) window_px[i] = '0;
  endfunction

  // sizes the block really uses: width saturates to 3..MAX_WIDTH, height to at least 3
  function automatic int eff_width();
    int w;
    w = int'(width_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(height_reg);
    if (h < 3) h = 3;
    return h;
  endfunction

  // 5 * centre minus the four direct neighbours, clamped to 0..255
  function automatic logic [CHAN_W-1:0] sharpen_chan(
    logic [CHAN_W-1:0] centre, logic [CHAN_W-1:0] up, logic [CHAN_W-1:0] down,
    logic [CHAN_W-1:0] left, logic [CHAN_W-1:0] right);
    int sum;
    sum = 5 * int'(centre) - int'(up) - int'(down) - int'(left) - int'(right);
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return CHAN_W'(sum);
  endfunction

  // advance the model by one accepted pixel, queue a result for interior pixels
  function automatic void predict_pixel(rsf_in_t d);
    int       w, h, col, row;
    rsf_pix_t px, up, mid;
    logic     row_end, img_end;
    rsf_out_t e;
    w   = eff_width();
    h   = eff_height();
    col = next_col;
    row = next_row;
    px.red   = d.red_in;
    px.green = d.green_in;
    px.blue  = d.blue_in;
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    up  = upper_line[col];
    mid = middle_line[col];
    upper_line[col]  = mid;
    middle_line[col] = px;
    // window columns slide left, newest column enters on the right
    for (int k = 0; k < 3; k++) begin
      window_px[k*3]   = window_px[k*3+1];
      window_px[k*3+1] = window_px[k*3+2];
    end
    window_px[2] = up;
    window_px[5] = mid;
    window_px[8] = px;
    row_end = (col >= w - 1);
    img_end = (row >= h - 1);
    if (col >= 2 && row >= 2) begin
      e.red_out    = sharpen_chan(window_px[4].red, window_px[1].red, window_px[7].red,
                                  window_px[3].red, window_px[5].red);
      e.green_out  = sharpen_chan(window_px[4].green, window_px[1].green, window_px[7].green,
                                  window_px[3].green, window_px[5].green);
      e.blue_out   = sharpen_chan(window_px[4].blue, window_px[1].blue, window_px[7].blue,
                                  window_px[3].blue, window_px[5].blue);
      e.out_column = COL_W'(col - 1);
      e.out_row    = HEIGHT_W'(row - 1);
      e.last_pixel = row_end && img_end;
      expected_pixels.push_back(e);
    end
    if (row_end) begin
      next_col = 0;
      next_row = img_end ? 0 : ((row + 1) & 16'hFFFF);
    end else begin
      next_col = col + 1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // channel values lean on 0 and 255 so both clamps get hit often
  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic rsf_in_t random_pixel();
    rsf_in_t p;
    p.red_in   = random_chan();
    p.green_in = random_chan();
    p.blue_in  = random_chan();
    return p;
  endfunction

  // offer one pixel word, optionally after idle cycles, and hold it until taken
  task automatic send_pixel(input rsf_in_t px);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    predict_pixel(px);
    words_sent++;
  endtask

  // sender pauses until every owed result came out, then lets the pipe settle
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
    else height_reg = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // send pixels until the counters wrap; from a clean start that is a whole image
  task automatic finish_image();
    do send_pixel(random_pixel()); while (next_col != 0 || next_row != 0);
  endtask

  // a 3x3 image built from one centre, four side and four corner pixels
  task automatic send_window(input rsf_in_t centre, input rsf_in_t side,
                             input rsf_in_t corner);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) send_pixel(centre);
      else if (i % 2 == 1) send_pixel(side);
      else send_pixel(corner);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus the long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (hold_start && hold_left == 0) hold_left = HOLD_OFF_CYCLES;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------

  function automatic void check_field(string field, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: output word with nothing expected, actual %p", $time, out_data);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("red_out",    16'(want.red_out),    16'(out_data.red_out));
        check_field("green_out",  16'(want.green_out),  16'(out_data.green_out));
        check_field("blue_out",   16'(want.blue_out),   16'(out_data.blue_out));
        check_field("out_column", 16'(want.out_column), 16'(out_data.out_column));
        check_field("out_row",    want.out_row,         out_data.out_row);
        check_field("last_pixel", 16'(want.last_pixel), 16'(out_data.last_pixel));
        results_checked++;
        if (want.last_pixel) images_closed++;
      end
    end
  end

  // watchdog: ends the run if no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still owed",
               $time, quiet_cycles, expected_pixels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset sizes: ten pixels at the 1024 reset width stay in the first row;
  // then the width drops to 5 mid-row, closing the row, and the height to 3
  task automatic test_reset_sizes();
    repeat (10) send_pixel(random_pixel());
    wait_results_done();
    write_reg(CFG_IMAGE_WIDTH, 16'h0005);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0003);
    finish_image();
    wait_results_done();
  endtask

  // 3x3 images: clamp high, clamp low and plain values, one per channel;
  // the width write carries junk in the bits above the 12-bit register
  task automatic test_kernel_clamps();
    write_reg(CFG_IMAGE_WIDTH, 16'hF003);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0003);
    send_window(rsf_in_t'{8'd255, 8'd0, 8'd128}, rsf_in_t'{8'd0, 8'd255, 8'd128},
                random_pixel());
    send_window(rsf_in_t'{8'd0, 8'd255, 8'd1}, rsf_in_t'{8'd255, 8'd0, 8'd0},
                random_pixel());
    send_window(rsf_in_t'{8'd51, 8'd52, 8'd63}, rsf_in_t'{8'd0, 8'd1, 8'd60},
                rsf_in_t'{8'd255, 8'd255, 8'd255});
    wait_results_done();
  endtask

  // sizes below the minimum act as 3; a 4095 width keeps the first row going
  // through column 39 until the width drops to 6 mid-row
  task automatic test_size_saturation();
    write_reg(CFG_IMAGE_WIDTH, 16'h0000);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0001);
    finish_image();
    wait_results_done();
    write_reg(CFG_IMAGE_WIDTH, 16'h0FFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0003);
    repeat (40) send_pixel(random_pixel());
    wait_results_done();
    write_reg(CFG_IMAGE_WIDTH, 16'h0006);
    finish_image();
    wait_results_done();
  endtask

  // tallest height, then width and height shrink mid-row: the column counter is past
  // the new row end and the row counter on the new last row, so the next pixel closes the image
  task automatic test_mid_image_resize();
    write_reg(CFG_IMAGE_WIDTH, 16'h0006);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    repeat (4 * 6 + 4) send_pixel(random_pixel());
    wait_results_done();
    write_reg(CFG_IMAGE_WIDTH, 16'h0004);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0005);
    finish_image();
    wait_results_done();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_output_hold_off();
    write_reg(CFG_IMAGE_WIDTH, 16'h0008);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0006);
    steady = 1'b1;
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    finish_image();
    steady = 1'b0;
    wait_results_done();
  endtask

  // back-to-back images with no idling on either side
  task automatic test_steady_stream();
    write_reg(CFG_IMAGE_WIDTH, 16'h0005);
    write_reg(CFG_IMAGE_HEIGHT, 16'h0004);
    steady = 1'b1;
    finish_image();
    finish_image();
    steady = 1'b0;
    wait_results_done();
  endtask

  // random small images; some are cut short, resized mid-image (width only
  // shrinks, so no stale line store entry is ever used) and then completed
  task automatic test_random_images();
    int start_words, w_raw, h_raw, part;
    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      steady = ($urandom_range(7) == 0);
      case ($urandom_range(9))
        0:       w_raw = $urandom_range(2);
        1:       w_raw = $urandom_range(20, 40);
        default: w_raw = $urandom_range(3, 14);
      endcase
      h_raw = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 7);
      if ($urandom_range(3) != 0)
        write_reg(CFG_IMAGE_WIDTH, {4'($urandom), 12'(w_raw)});
      write_reg(CFG_IMAGE_HEIGHT, 16'(h_raw));
      if ($urandom_range(4) == 0) begin
        part = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (part) send_pixel(random_pixel());
        wait_results_done();
        write_reg(CFG_IMAGE_WIDTH, 16'($urandom_range(0, eff_width())));
        write_reg(CFG_IMAGE_HEIGHT, 16'($urandom_range(0, 9)));
      end
      finish_image();
      wait_results_done();
    end
    steady = 1'b0;
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_sizes();
    test_kernel_clamps();
    test_size_saturation();
    test_mid_image_resize();
    test_output_hold_off();
    test_steady_stream();
    test_random_images();
    wait_results_done();
    $display("run covered %0d pixel words in, %0d results checked, %0d image ends",
             words_sent, results_checked, images_closed);
    $display("sizes 3x3 to 40 wide, both clamps, mid-image resizes, long output hold-off");
    if (failures == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
